[sv/spq_pkg.sv]
package spq_pkg;

  // Number of cells in the queue.
  localparam int unsigned CAPACITY = 16;
  // Width of the entry count, which must hold CAPACITY itself.
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_CLEAR   = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] item_data;
    logic signed [31:0] item_priority;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_data;
    logic [1:0]         status;
    logic               queue_empty;
  } out_t;

  // Broadcast from the top level to every cell in the chain.
  typedef struct packed {
    logic               enq;
    logic               deq;
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } cell_ctl_t;

endpackage

[sv/spq_cell.sv]
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  logic               left_ge,
  input  logic signed [31:0] left_data,
  input  logic signed [31:0] left_prio,
  input  logic signed [31:0] right_data,
  input  logic signed [31:0] right_prio,
  output logic               ge,
  output logic signed [31:0] data,
  output logic signed [31:0] prio
);

  logic signed [31:0] data_next;
  logic signed [31:0] prio_next;

  // This entry stays ahead of a new item when its priority is at least as high.
  assign ge = occupied && (prio >= ctl.prio);

  // An enqueue keeps, takes the new item, or takes the left neighbor's entry;
  // a dequeue moves every entry one cell toward the front.
  always_comb begin
    data_next = data;
    prio_next = prio;
    if (ctl.enq) begin
      if (!ge) begin
        if (left_ge) begin
          data_next = ctl.data;
          prio_next = ctl.prio;
        end else begin
          data_next = left_data;
          prio_next = left_prio;
        end
      end
    end else if (ctl.deq) begin
      data_next = right_data;
      prio_next = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    prio <= prio_next;
  end

endmodule

[sv/spq_out_fifo.sv]
module spq_out_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spq_pkg::out_t push_beat,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output spq_pkg::out_t out_item
);

  spq_pkg::out_t e0;
  spq_pkg::out_t e1;
  logic [1:0]    cnt;
  logic          pop;

  assign pop       = (cnt != 2'd0) && !out_stall;
  assign full      = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_item  = e0;

  // Two-entry skid buffer: the head is always the oldest beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (cnt == 2'd0) begin
            e0 <= push_beat;
          end else begin
            e1 <= push_beat;
          end
          cnt <= cnt + 2'd1;
        end
        2'b01: begin
          e0  <= e1;
          cnt <= cnt - 2'd1;
        end
        2'b11: begin
          if (cnt == 2'd1) begin
            e0 <= push_beat;
          end else begin
            e0 <= e1;
            e1 <= push_beat;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("skid buffer overflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("skid buffer count out of range");

  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && pop) |=> (cnt == 2'd1 || cnt == 2'd2))
    else $error("skid buffer lost a beat");

endmodule

[sv/sorted_priority_queue.sv]
// Sorted priority queue, highest priority at the front, up to CAPACITY entries.
// Input channel in_valid/in_stall/in_item carries a command with data and
// priority: enqueue, dequeue, peek or clear. Each accepted beat yields exactly
// one beat on out_valid/out_stall/out_item with the front data (dequeue, peek),
// a status (ok, empty, full and dropped) and whether the queue is now empty.
// Equal priorities leave in arrival order.
// The queue is a chain of cells; every cell compares its priority with the new
// item in parallel and shifts left or right by one place in the same cycle, so
// one beat is taken per cycle unless the output buffer is full; its result is
// registered in the output skid buffer. The rate is set by the cell update plus
// the two-entry output skid buffer.
// When the receiver stalls, up to two results are held; in_stall rises only
// once both are occupied and falls as soon as one is taken.
// Synchronous reset empties the queue and the output buffer; cell contents are
// not cleared and are never read before being written.
module sorted_priority_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  spq_pkg::in_t in_item,
  output logic         out_valid,
  input  logic         out_stall,
  output spq_pkg::out_t out_item
);

  logic [spq_pkg::CNT_W-1:0] count;
  logic [spq_pkg::CNT_W-1:0] count_next;
  logic                      accept;
  logic                      is_empty;
  logic                      is_full;
  spq_pkg::cell_ctl_t        ctl;
  spq_pkg::out_t             res;
  logic                      buf_full;

  logic               ge   [spq_pkg::CAPACITY];
  logic signed [31:0] dat  [spq_pkg::CAPACITY];
  logic signed [31:0] pri  [spq_pkg::CAPACITY];

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;
  assign is_empty = (count == '0);
  assign is_full  = (count == spq_pkg::CNT_W'(spq_pkg::CAPACITY));

  // Command decode into the cell broadcast, the next count and the result beat.
  always_comb begin
    ctl.enq  = 1'b0;
    ctl.deq  = 1'b0;
    ctl.data = in_item.item_data;
    ctl.prio = in_item.item_priority;
    count_next = count;
    res.result_data = '0;
    res.status      = spq_pkg::ST_OK;
    if (accept) begin
      unique case (spq_pkg::command_t'(in_item.command))
        spq_pkg::CMD_ENQUEUE: begin
          if (is_full) begin
            res.status = spq_pkg::ST_FULL;
          end else begin
            ctl.enq    = 1'b1;
            count_next = count + spq_pkg::CNT_W'(1);
          end
        end
        spq_pkg::CMD_DEQUEUE: begin
          if (is_empty) begin
            res.status = spq_pkg::ST_EMPTY;
          end else begin
            ctl.deq         = 1'b1;
            res.result_data = dat[0];
            count_next      = count - spq_pkg::CNT_W'(1);
          end
        end
        spq_pkg::CMD_PEEK: begin
          if (is_empty) begin
            res.status = spq_pkg::ST_EMPTY;
          end else begin
            res.result_data = dat[0];
          end
        end
        spq_pkg::CMD_CLEAR: begin
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
    res.queue_empty = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // The chain of cells; cell 0 is the front.
  for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
    logic               occ;
    logic               lge;
    logic signed [31:0] ld;
    logic signed [31:0] lp;
    logic signed [31:0] rd;
    logic signed [31:0] rp;

    assign occ = (spq_pkg::CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign lge = 1'b1;
      assign ld  = in_item.item_data;
      assign lp  = in_item.item_priority;
    end else begin : g_rest
      assign lge = ge[i-1];
      assign ld  = dat[i-1];
      assign lp  = pri[i-1];
    end

    if (i == spq_pkg::CAPACITY - 1) begin : g_last
      assign rd = dat[i];
      assign rp = pri[i];
    end else begin : g_inner
      assign rd = dat[i+1];
      assign rp = pri[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ),
      .left_ge    (lge),
      .left_data  (ld),
      .left_prio  (lp),
      .right_data (rd),
      .right_prio (rp),
      .ge         (ge[i]),
      .data       (dat[i]),
      .prio       (pri[i])
    );
  end

  spq_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_beat (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
    else $error("entry count exceeds capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && in_item.command == spq_pkg::CMD_CLEAR) |=> (count == '0))
    else $error("clear left entries behind");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && in_item.command == spq_pkg::CMD_ENQUEUE && !is_full)
      |=> (count == $past(count) + spq_pkg::CNT_W'(1)))
    else $error("enqueue did not add an entry");

  a_front_order: assert property (@(posedge clk) disable iff (rst)
    (count >= spq_pkg::CNT_W'(2)) |-> (pri[0] >= pri[1]))
    else $error("front entries out of order");

endmodule

[verif/tb_sorted_priority_queue.sv]
module tb_sorted_priority_queue;

  // One stored pair of the shadow queue.
  typedef struct {
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } entry_t;

  localparam logic signed [31:0] PRIO_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] PRIO_MAX = 32'sh7FFF_FFFF;
  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned RUN_LIMIT_CYCLES = 200000;
  localparam int unsigned DRAIN_LIMIT_CYCLES = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  spq_pkg::in_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  spq_pkg::out_t out_item;

  // Shadow copy of the sorted contents and results still owed by the block.
  entry_t shadow_queue[$];
  spq_pkg::out_t pending_results[$];
  spq_pkg::out_t oldest_result;

  int idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int command_tally[4] = '{0, 0, 0, 0};
  int full_drops = 0;
  int empty_hits = 0;
  int checked_beats = 0;

  sorted_priority_queue u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #HALF_PERIOD clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #(2 * HALF_PERIOD * RUN_LIMIT_CYCLES);
    $display("Regression FAIL");
    $finish;
  end

  // Applies one command to the shadow queue and returns the result it owes.
  function automatic spq_pkg::out_t apply_command(spq_pkg::in_t item);
    spq_pkg::out_t res;
    entry_t entry;
    int pos;
    res = '0;
    case (item.command)
      spq_pkg::CMD_ENQUEUE: begin
        if (shadow_queue.size() >= spq_pkg::CAPACITY) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          entry.data = item.item_data;
          entry.prio = item.item_priority;
          pos = 0;
          // Equal priorities go behind the ones already stored.
          while (pos < shadow_queue.size() &&
                 $signed(shadow_queue[pos].prio) >= $signed(item.item_priority))
            pos++;
          shadow_queue.insert(pos, entry);
        end
      end
      spq_pkg::CMD_DEQUEUE: begin
        if (shadow_queue.size() == 0) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          entry = shadow_queue.pop_front();
          res.result_data = entry.data;
        end
      end
      spq_pkg::CMD_PEEK: begin
        if (shadow_queue.size() == 0) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          res.result_data = shadow_queue[0].data;
        end
      end
      default: begin
        shadow_queue.delete();
      end
    endcase
    res.queue_empty = (shadow_queue.size() == 0);
    return res;
  endfunction

  function automatic spq_pkg::in_t make_item(spq_pkg::command_t cmd,
                                             logic signed [31:0] data,
                                             logic signed [31:0] prio);
    spq_pkg::in_t item;
    item.command = cmd;
    item.item_data = data;
    item.item_priority = prio;
    return item;
  endfunction

  // Many priorities fall in a narrow band or at the extremes so that ties are common.
  function automatic logic signed [31:0] random_priority();
    logic signed [31:0] prio;
    case ($urandom_range(9))
      0: prio = PRIO_MIN;
      1: prio = PRIO_MAX;
      2, 3, 4, 5: prio = int'($urandom_range(7)) - 3;
      default: prio = $urandom;
    endcase
    return prio;
  endfunction

  // Receiver side: random stall, changed at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Predict on every accepted input beat and check every accepted output beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(apply_command(in_item));
        command_tally[in_item.command]++;
        if (pending_results[$].status == spq_pkg::ST_FULL) full_drops++;
        if (pending_results[$].status == spq_pkg::ST_EMPTY) empty_hits++;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat arrived with no expectation waiting");
          error_count++;
        end else begin
          oldest_result = pending_results.pop_front();
          checked_beats++;
          if (out_item.result_data !== oldest_result.result_data) begin
            $error("result_data: expected %0d, actual %0d",
                   oldest_result.result_data, out_item.result_data);
            error_count++;
          end
          if (out_item.status !== oldest_result.status) begin
            $error("status: expected %0d, actual %0d",
                   oldest_result.status, out_item.status);
            error_count++;
          end
          if (out_item.queue_empty !== oldest_result.queue_empty) begin
            $error("queue_empty: expected %0d, actual %0d",
                   oldest_result.queue_empty, out_item.queue_empty);
            error_count++;
          end
        end
      end
    end
  end

  // Sends one beat after a random gap; returns at the falling edge after it
  // was accepted, with valid still high.
  task automatic send_beat(input spq_pkg::in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Dequeue, peek and clear on a queue that was just reset.
  task automatic test_empty_queue();
    send_beat(make_item(spq_pkg::CMD_DEQUEUE, 32'sd0, 32'sd0));
    send_beat(make_item(spq_pkg::CMD_PEEK, 32'sd0, 32'sd0));
    send_beat(make_item(spq_pkg::CMD_CLEAR, 32'sd0, 32'sd0));
  endtask

  // Fill to capacity with extreme and tied priorities, then overflow it.
  task automatic test_full_queue();
    logic signed [31:0] prios [16] = '{PRIO_MAX, PRIO_MIN, 0, -1, 1, 5, 5, 5,
                                       PRIO_MAX, PRIO_MIN, 0, 3, -7, 100, 100, -1};
    logic signed [31:0] datas [16] = '{32'sh8000_0000, 32'sh7FFF_FFFF, -1, 0,
                                       32'shAAAA_AAAA, 32'sh5555_5555, 1, 2,
                                       3, 4, 5, 6, 7, 8, 9, 10};
    for (int i = 0; i < 16; i++) begin
      send_beat(make_item(spq_pkg::CMD_ENQUEUE, datas[i], prios[i]));
    end
    send_beat(make_item(spq_pkg::CMD_ENQUEUE, 32'sh1234_5678, PRIO_MAX));
    send_beat(make_item(spq_pkg::CMD_PEEK, 32'sd0, 32'sd0));
  endtask

  // Take from the front, then clear a non-empty queue and look at it.
  task automatic test_dequeue_and_clear();
    send_beat(make_item(spq_pkg::CMD_DEQUEUE, 32'sd0, 32'sd0));
    send_beat(make_item(spq_pkg::CMD_DEQUEUE, 32'sd0, 32'sd0));
    send_beat(make_item(spq_pkg::CMD_CLEAR, 32'sd0, 32'sd0));
    send_beat(make_item(spq_pkg::CMD_PEEK, 32'sd0, 32'sd0));
  endtask

  // Random commands in stretches that lean toward filling, draining or
  // balance, so the queue swings between empty and full.
  task automatic test_random_traffic(input int idle, input int stall,
                                     input int beats);
    int mode;
    int roll;
    spq_pkg::command_t cmd;
    idle_pct = idle;
    stall_pct = stall;
    mode = 0;
    for (int i = 0; i < beats; i++) begin
      if (i % 40 == 0) mode = $urandom_range(2);
      roll = $urandom_range(99);
      case (mode)
        0: cmd = (roll < 75) ? spq_pkg::CMD_ENQUEUE :
                 (roll < 90) ? spq_pkg::CMD_DEQUEUE :
                 (roll < 97) ? spq_pkg::CMD_PEEK : spq_pkg::CMD_CLEAR;
        1: cmd = (roll < 20) ? spq_pkg::CMD_ENQUEUE :
                 (roll < 85) ? spq_pkg::CMD_DEQUEUE :
                 (roll < 97) ? spq_pkg::CMD_PEEK : spq_pkg::CMD_CLEAR;
        default: cmd = (roll < 45) ? spq_pkg::CMD_ENQUEUE :
                       (roll < 80) ? spq_pkg::CMD_DEQUEUE :
                       (roll < 95) ? spq_pkg::CMD_PEEK : spq_pkg::CMD_CLEAR;
      endcase
      send_beat(make_item(cmd, $urandom, random_priority()));
    end
  endtask

  initial begin
    int drain_cycles;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_full_queue();
    test_dequeue_and_clear();
    test_random_traffic(0, 0, 330);
    test_random_traffic(77, 0, 320);
    test_random_traffic(0, 77, 320);
    test_random_traffic(19, 19, 330);

    // Let the last results come out.
    in_valid <= 1'b0;
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT_CYCLES) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (8) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end

    $display("Checked %0d result beats: %0d enqueue, %0d dequeue, %0d peek, %0d clear.",
             checked_beats, command_tally[spq_pkg::CMD_ENQUEUE],
             command_tally[spq_pkg::CMD_DEQUEUE], command_tally[spq_pkg::CMD_PEEK],
             command_tally[spq_pkg::CMD_CLEAR]);
    $display("Saw %0d drops on a full queue and %0d reads of an empty one.",
             full_drops, empty_hits);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
